// File: rtl/crri_pkg.sv
// Shared types, operation codes and decode functions for the CIGAR
// reference-to-read index locator. No dependencies.
package crri_pkg;

    localparam int OP_W     = 4;
    localparam int LEN_W    = 28;
    localparam int COORD_W  = 32;
    localparam int INDEX_W  = 32;
    localparam int SUM_W    = COORD_W + 2;

    localparam logic [OP_W-1:0] OP_MATCH     = 4'd0;
    localparam logic [OP_W-1:0] OP_INS       = 4'd1;
    localparam logic [OP_W-1:0] OP_DEL       = 4'd2;
    localparam logic [OP_W-1:0] OP_SKIP      = 4'd3;
    localparam logic [OP_W-1:0] OP_SOFT_CLIP = 4'd4;
    localparam logic [OP_W-1:0] OP_HARD_CLIP = 4'd5;
    localparam logic [OP_W-1:0] OP_PAD       = 4'd6;
    localparam logic [OP_W-1:0] OP_EQUAL     = 4'd7;
    localparam logic [OP_W-1:0] OP_DIFF      = 4'd8;

    localparam logic signed [SUM_W-1:0] REF_MAX = 34'sd2147483647;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [LEN_W-1:0]          len;
        logic                      first;
        logic                      last;
        logic signed [COORD_W-1:0] align_start;
        logic signed [COORD_W-1:0] ref_coord;
    } t_elem;

    typedef struct packed {
        logic                 found;
        logic [INDEX_W-1:0]   read_index;
        logic [OP_W-1:0]      element_op;
    } t_result;

    function automatic logic eats_read(input logic [OP_W-1:0] op);
        logic res;
        case (op) inside
            OP_MATCH, OP_INS, OP_SOFT_CLIP, OP_EQUAL, OP_DIFF: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic eats_ref(input logic [OP_W-1:0] op);
        logic res;
        case (op) inside
            OP_MATCH, OP_DEL, OP_SKIP, OP_SOFT_CLIP, OP_EQUAL, OP_DIFF: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/crri_in_stage.sv
// Input register for CIGAR elements with its valid flag.
// Depends on crri_pkg.
module crri_in_stage
    import crri_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_elem i_elem,
    output logic  o_valid,
    output t_elem o_elem,
    input  logic  i_pop
);

    logic  r_valid;
    logic  n_valid;
    t_elem r_elem;

    assign o_ready = !r_valid || i_pop;
    assign n_valid = o_ready ? i_valid : r_valid;
    assign o_valid = r_valid;
    assign o_elem  = r_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_elem <= i_elem;
        end
    end

endmodule

// File: rtl/crri_locate.sv
// Running read and reference positions and the bracketing test for one element.
// Depends on crri_pkg.
module crri_locate
    import crri_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_elem_valid,
    input  t_elem   i_elem,
    output logic    o_elem_pop,
    input  logic    i_res_ready,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [INDEX_W-1:0]        r_read;
    logic signed [COORD_W-1:0] r_ref;
    logic signed [COORD_W-1:0] r_tgt;
    logic                      r_ans;

    logic [INDEX_W-1:0]        n_read;
    logic signed [COORD_W-1:0] n_ref;
    logic signed [COORD_W-1:0] n_tgt;
    logic                      n_ans;

    logic [INDEX_W-1:0]        eff_read;
    logic signed [COORD_W-1:0] eff_ref;
    logic signed [COORD_W-1:0] eff_tgt;
    logic                      eff_ans;
    logic                      cr;
    logic                      cf;
    logic signed [SUM_W-1:0]   ref_x;
    logic signed [SUM_W-1:0]   tgt_x;
    logic signed [SUM_W-1:0]   last_ref;
    logic signed [SUM_W-1:0]   offset;
    logic [INDEX_W-1:0]        read_next;
    logic signed [COORD_W-1:0] ref_next;
    logic                      hit;
    logic                      go;

    assign go         = i_elem_valid && i_res_ready;
    assign o_elem_pop = go;

    always_comb begin
        eff_read = i_elem.first ? '0 : r_read;
        eff_ref  = i_elem.first ? i_elem.align_start : r_ref;
        eff_tgt  = i_elem.first ? i_elem.ref_coord : r_tgt;
        eff_ans  = i_elem.first ? 1'b0 : r_ans;
        cr       = eats_read(i_elem.op);
        cf       = eats_ref(i_elem.op);

        ref_x    = SUM_W'(eff_ref);
        tgt_x    = SUM_W'(eff_tgt);
        last_ref = ref_x + (cf ? $signed({6'd0, i_elem.len}) : '0);
        offset   = tgt_x - ref_x;
        read_next = eff_read + (cr ? {4'd0, i_elem.len} : '0);
        ref_next  = (last_ref > REF_MAX) ? COORD_W'(REF_MAX) : last_ref[COORD_W-1:0];
        hit       = (ref_x <= tgt_x) && (tgt_x < last_ref);

        o_res.found      = hit;
        o_res.read_index = '0;
        o_res.element_op = '0;
        if (hit) begin
            o_res.read_index = cr ? (eff_read + offset[INDEX_W-1:0]) : read_next;
            o_res.element_op = i_elem.op;
        end
        o_res_valid = go && !eff_ans && (hit || i_elem.last);

        n_read = r_read;
        n_ref  = r_ref;
        n_tgt  = r_tgt;
        n_ans  = r_ans;
        if (go) begin
            n_tgt = eff_tgt;
            if (eff_ans) begin
                n_read = eff_read;
                n_ref  = eff_ref;
                n_ans  = 1'b1;
            end else begin
                n_read = read_next;
                n_ref  = ref_next;
                n_ans  = hit || i_elem.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read <= '0;
            r_ref  <= '0;
            r_tgt  <= '0;
            r_ans  <= 1'b0;
        end else begin
            r_read <= n_read;
            r_ref  <= n_ref;
            r_tgt  <= n_tgt;
            r_ans  <= n_ans;
        end
    end

endmodule

// File: rtl/crri_out_reg.sv
// Result register that holds one word until the downstream side takes it.
// Depends on crri_pkg.
module crri_out_reg
    import crri_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/cigar_ref_to_read_index.sv
// Top level of the CIGAR reference-to-read index locator.
// Depends on crri_pkg, crri_in_stage, crri_locate and crri_out_reg.
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata: op[3:0] len[31:4] start[63:32] target[95:64];
//                       tuser: first element; tlast: last element
//  m_axis    out        tdata: read index[31:0] op[35:32]; tuser: found
//
// One element is taken per cycle while the result register can accept a result.
// Running positions update from the element in the input register, which sets the rate.
// Reset is synchronous and clears the valid flags and the running positions.
// A stalled output holds the result register and then the input register.
module cigar_ref_to_read_index
    import crri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // cigar_op, op_length, alignment_start, ref_coord
    input  logic        i_s_axis_tlast,   // last_element
    input  logic        i_s_axis_tuser,   // first_element
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // read_index, element_op, zero fill
    output logic        o_m_axis_tuser    // found
);

    t_elem   in_elem;
    t_elem   st_elem;
    logic    st_valid;
    logic    st_pop;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out_res;

    always_comb begin
        in_elem.op          = i_s_axis_tdata[3:0];
        in_elem.len         = i_s_axis_tdata[31:4];
        in_elem.first       = i_s_axis_tuser;
        in_elem.last        = i_s_axis_tlast;
        in_elem.align_start = i_s_axis_tdata[63:32];
        in_elem.ref_coord   = i_s_axis_tdata[95:64];
    end

    crri_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_elem  (in_elem),
        .o_valid (st_valid),
        .o_elem  (st_elem),
        .i_pop   (st_pop)
    );

    crri_locate u_locate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_valid (st_valid),
        .i_elem       (st_elem),
        .o_elem_pop   (st_pop),
        .i_res_ready  (res_ready),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    crri_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {4'd0, out_res.element_op, out_res.read_index};
    assign o_m_axis_tuser = out_res.found;

endmodule

// File: bench/cigar_ref_to_read_index_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cigar_ref_to_read_index: directed rows, then random CIGAR runs.
// Needs crri_pkg and the block's RTL; results are checked against typed rows or a locator model kept here.
module cigar_ref_to_read_index_tb
    import crri_pkg::*;
;

    localparam logic [OP_W-1:0]  OP_UNK_LO    = 4'd9;
    localparam logic [OP_W-1:0]  OP_UNK_HI    = 4'd15;
    localparam logic [LEN_W-1:0] LEN_MAX      = 28'hFFFFFFF;
    localparam logic signed [31:0] COORD_MIN  = 32'sh80000000;
    localparam logic signed [31:0] COORD_MAX  = 32'sh7FFFFFFF;
    localparam int RANDOM_WORDS = 1700;
    localparam int CALM_WORDS   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int N_DIR        = 25;

    typedef struct {
        t_elem   w;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    logic [31:0]        cur_read_end = '0;
    logic signed [31:0] cur_ref_end = '0;
    logic signed [31:0] cur_target = '0;
    bit                 cur_answered = 1'b0;

    t_result  pending_locations[$];
    t_dir_row dir_rows[N_DIR];
    bit       calm = 1'b0;
    bit       hold_pending = 1'b0;
    int       n_words = 0;
    int       n_live = 0;
    int       n_results = 0;
    int       n_hits = 0;
    int       n_errors = 0;
    int       n_holds = 0;

    cigar_ref_to_read_index dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("cigar_ref_to_read_index: mismatch");
        $finish;
    end

    function automatic bit reads_bases(input logic [OP_W-1:0] op);
        case (op)
            OP_MATCH, OP_INS, OP_SOFT_CLIP, OP_EQUAL, OP_DIFF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit spans_ref(input logic [OP_W-1:0] op);
        case (op)
            OP_MATCH, OP_DEL, OP_SKIP, OP_SOFT_CLIP, OP_EQUAL, OP_DIFF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_dir_row mk_row(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                                        input bit first, input bit last,
                                        input logic signed [31:0] start,
                                        input logic signed [31:0] target, input bit typed,
                                        input bit found, input logic [31:0] idx,
                                        input logic [OP_W-1:0] eop);
        t_dir_row r;
        r.w.op = op;
        r.w.len = len;
        r.w.first = first;
        r.w.last = last;
        r.w.align_start = start;
        r.w.ref_coord = target;
        r.typed = typed;
        r.res.found = found;
        r.res.read_index = idx;
        r.res.element_op = eop;
        return r;
    endfunction

    // Running read/reference ends decide whether this element brackets the target.
    task automatic locate_target(input t_elem w, output bit has_res, output t_result r);
        longint      first_ref;
        longint      last_ref;
        longint      tg;
        logic [31:0] first_read;
        bit          cr;
        bit          cf;
        has_res = 1'b0;
        r = '0;
        if (w.first) begin
            cur_ref_end = w.align_start;
            cur_target = w.ref_coord;
            cur_read_end = '0;
            cur_answered = 1'b0;
        end
        if (!cur_answered) begin
            cr = reads_bases(w.op);
            cf = spans_ref(w.op);
            first_ref = longint'(cur_ref_end);
            last_ref = first_ref + (cf ? longint'(w.len) : 64'sd0);
            first_read = cur_read_end;
            cur_read_end = cur_read_end + (cr ? 32'(w.len) : 32'd0);
            cur_ref_end = (last_ref > 64'sd2147483647) ? COORD_MAX : 32'(last_ref);
            tg = longint'(cur_target);
            if (first_ref <= tg && tg < last_ref) begin
                r.found = 1'b1;
                r.read_index = cr ? first_read + 32'(tg - first_ref) : cur_read_end;
                r.element_op = w.op;
                has_res = 1'b1;
                cur_answered = 1'b1;
            end else if (w.last) begin
                has_res = 1'b1;
                cur_answered = 1'b1;
            end
        end
    endtask

    task automatic send_word(input t_elem w, input bit typed, input t_result typed_res);
        bit      has_res;
        bit      live;
        t_result r;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {w.ref_coord, w.align_start, w.len, w.op};
        i_s_axis_tuser <= w.first;
        i_s_axis_tlast <= w.last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        live = w.first || !cur_answered;
        locate_target(w, has_res, r);
        if (typed)
            pending_locations.push_back(typed_res);
        else if (has_res)
            pending_locations.push_back(r);
        n_words++;
        if (live)
            n_live++;
    endtask

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 1'b0;
                n_holds++;
            end else if (calm) begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 16))
                    @(posedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_locations.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word, expected none, actual found %0b index %h op %0d",
                         $time, o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[35:32]);
            end else begin
                exp_r = pending_locations.pop_front();
                n_results++;
                if (exp_r.found)
                    n_hits++;
                if (o_m_axis_tuser !== exp_r.found) begin
                    n_errors++;
                    $display("%0t: found expected %0b actual %0b",
                             $time, exp_r.found, o_m_axis_tuser);
                end
                if (o_m_axis_tdata[31:0] !== exp_r.read_index) begin
                    n_errors++;
                    $display("%0t: read index expected %h actual %h",
                             $time, exp_r.read_index, o_m_axis_tdata[31:0]);
                end
                if (o_m_axis_tdata[35:32] !== exp_r.element_op) begin
                    n_errors++;
                    $display("%0t: element op expected %0d actual %0d",
                             $time, exp_r.element_op, o_m_axis_tdata[35:32]);
                end
            end
        end
    end

    initial begin
        t_elem              cigar[$];
        t_elem              e;
        int                 kind;
        int                 n_elem;
        int                 sel;
        bit                 hold_done;
        bit                 pause_done;
        longint             span;
        longint             tgt_l;
        logic signed [31:0] start;

        hold_done = 1'b0;
        pause_done = 1'b0;
        dir_rows[0]  = mk_row(OP_MATCH, 5, 0, 1, 0, 0, 1, 1, 0, OP_MATCH);
        dir_rows[1]  = mk_row(OP_MATCH, 10, 1, 1, 100, 50, 1, 0, 0, OP_MATCH);
        dir_rows[2]  = mk_row(OP_MATCH, 10, 1, 0, 100, 200, 0, 0, 0, OP_MATCH);
        dir_rows[3]  = mk_row(OP_DEL, 5, 0, 1, 0, 0, 1, 0, 0, OP_MATCH);
        dir_rows[4]  = mk_row(OP_SOFT_CLIP, 4, 1, 0, 0, 12, 0, 0, 0, OP_MATCH);
        dir_rows[5]  = mk_row(OP_MATCH, 10, 0, 1, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[6]  = mk_row(OP_MATCH, 3, 1, 0, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[7]  = mk_row(OP_INS, 2, 0, 0, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[8]  = mk_row(OP_MATCH, 4, 0, 1, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[9]  = mk_row(OP_MATCH, 5, 1, 0, 10, 100, 0, 0, 0, OP_MATCH);
        dir_rows[10] = mk_row(OP_MATCH, 4, 1, 1, -20, -18, 0, 0, 0, OP_MATCH);
        dir_rows[11] = mk_row(OP_MATCH, 5, 1, 0, 0, 5, 0, 0, 0, OP_MATCH);
        dir_rows[12] = mk_row(OP_DEL, 3, 0, 1, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[13] = mk_row(OP_SKIP, 4, 1, 1, 0, 2, 0, 0, 0, OP_MATCH);
        dir_rows[14] = mk_row(OP_UNK_HI, 7, 1, 0, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[15] = mk_row(OP_HARD_CLIP, 3, 0, 0, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[16] = mk_row(OP_PAD, 2, 0, 0, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[17] = mk_row(OP_UNK_LO, 1, 0, 0, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[18] = mk_row(OP_MATCH, 1, 0, 1, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[19] = mk_row(OP_INS, 5, 1, 0, COORD_MAX - 2, COORD_MAX, 0, 0, 0, OP_MATCH);
        dir_rows[20] = mk_row(OP_MATCH, LEN_MAX, 0, 1, 0, 0, 0, 0, 0, OP_MATCH);
        dir_rows[21] = mk_row(OP_MATCH, LEN_MAX, 1, 0, 2147483000, -5, 0, 0, 0, OP_MATCH);
        dir_rows[22] = mk_row(OP_EQUAL, 10, 0, 1, 0, 0, 1, 0, 0, OP_MATCH);
        dir_rows[23] = mk_row(OP_DIFF, LEN_MAX, 1, 1, COORD_MIN, COORD_MIN, 1, 1, 0, OP_DIFF);
        dir_rows[24] = mk_row(OP_EQUAL, 0, 1, 1, COORD_MAX, COORD_MAX, 1, 0, 0, OP_MATCH);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        n_live = 0;
        while (n_words < RANDOM_WORDS) begin
            if (!hold_done && n_words >= 400) begin
                hold_pending = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && n_words >= 900) begin
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_locations.size() != 0);
                pause_done = 1'b1;
            end
            if (n_words >= RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            cigar.delete();
            kind = $urandom_range(0, 99);
            if (kind < 2) begin
                // Long insertions wrap the read position before the target is reached.
                for (int k = 0; k < 17; k++) begin
                    e = '0;
                    e.op = OP_INS;
                    e.len = LEN_MAX;
                    e.first = (k == 0);
                    e.align_start = 0;
                    e.ref_coord = $urandom_range(0, 99);
                    cigar.push_back(e);
                end
                e = '0;
                e.op = OP_MATCH;
                e.len = 100;
                e.last = 1'b1;
                cigar.push_back(e);
            end else if (kind < 12) begin
                e.op = OP_W'($urandom_range(0, 15));
                e.len = LEN_W'($urandom);
                e.first = 1'($urandom_range(0, 1));
                e.last = 1'($urandom_range(0, 1));
                e.align_start = $urandom;
                e.ref_coord = $urandom;
                cigar.push_back(e);
            end else begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    start = COORD_MIN;
                else if (sel == 1)
                    start = COORD_MAX;
                else if (sel == 2)
                    start = $urandom;
                else
                    start = int'($urandom_range(0, 4000)) - 2000;
                n_elem = $urandom_range(1, 6);
                span = 0;
                for (int k = 0; k < n_elem; k++) begin
                    e = '0;
                    e.op = ($urandom_range(0, 9) == 0) ?
                           OP_W'($urandom_range(OP_UNK_LO, OP_UNK_HI)) :
                           OP_W'($urandom_range(0, 8));
                    sel = $urandom_range(0, 15);
                    if (sel == 0)
                        e.len = 0;
                    else if (sel == 1)
                        e.len = LEN_MAX;
                    else if (sel == 2)
                        e.len = LEN_W'($urandom);
                    else
                        e.len = LEN_W'($urandom_range(1, 30));
                    e.first = (k == 0);
                    e.last = (k == n_elem - 1);
                    e.align_start = (k == 0) ? start : 32'($urandom);
                    e.ref_coord = $urandom;
                    if (spans_ref(e.op))
                        span += longint'(e.len);
                    cigar.push_back(e);
                end
                sel = $urandom_range(0, 9);
                if (sel <= 5 && span > 0)
                    tgt_l = longint'(start) + longint'($urandom_range(32'(span - 1), 0));
                else if (sel == 6)
                    tgt_l = longint'(start) - longint'($urandom_range(1, 50));
                else if (sel == 7)
                    tgt_l = longint'(start) + span + longint'($urandom_range(0, 50));
                else
                    tgt_l = longint'($urandom);
                cigar[0].ref_coord = 32'(tgt_l);
                if (kind < 22) begin
                    sel = $urandom_range(0, 2);
                    if (sel == 0)
                        cigar[cigar.size() - 1].last = 1'b0;
                    else if (sel == 1)
                        cigar[0].first = 1'b0;
                    else
                        cigar[$urandom_range(0, cigar.size() - 1)].last = 1'b1;
                end
            end
            foreach (cigar[i])
                send_word(cigar[i], 1'b0, '0);
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_locations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d live), checked %0d results: %0d hits, %0d not found.",
                 n_words, n_live, n_results, n_hits, n_results - n_hits);
        $display("Output hold-offs: %0d; errors: %0d.", n_holds, n_errors);
        if (n_errors == 0)
            $display("cigar_ref_to_read_index: match");
        else
            $display("cigar_ref_to_read_index: mismatch");
        $finish;
    end

endmodule
